>>> rtl/seven_segment_scan_driver_top_macros.svh
// Assertion macros shared by the seven-segment scan driver RTL.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");

`else

`define SSD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/ssd_pkg.sv
// Shared widths, command codes and character constants of the seven-segment scan driver.
package ssd_pkg;

    localparam int DIGITS   = 4;
    localparam int DIGIT_W  = $clog2(DIGITS);
    localparam int CMD_W    = 3;
    localparam int NUMBER_W = 16;
    localparam int CHAR_W   = 8;
    localparam int SEG_W    = 8;
    localparam int PHASE_W  = 3;

    localparam logic [CMD_W-1:0] CMD_SET_NUMBER = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET_CHAR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SCAN_TICK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_START      = 3'd4;

    localparam logic [PHASE_W-1:0] PHASE_WRAP = 3'd4;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_F     = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_U     = 8'h55;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h67;

    localparam logic [SEG_W-1:0] SEG_DARK = 8'hFF;

    localparam logic signed [NUMBER_W-1:0] NUM_MIN = -16'sd999;
    localparam logic signed [NUMBER_W-1:0] NUM_MAX = 16'sd9999;

    typedef logic [DIGITS-1:0][CHAR_W-1:0] digit_row_t;

    typedef struct packed {
        logic       known;
        logic [6:0] pattern;
    } seg_decode_t;

endpackage

>>> rtl/ssd_req_if.sv
// Request channel of the seven-segment scan driver: command beats with their payload.
interface ssd_req_if import ssd_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [NUMBER_W-1:0] number;
    logic [CHAR_W-1:0]          character;
    logic [DIGIT_W-1:0]         position;

    modport source (output valid, output cmd, output number, output character,
                    output position, input ready);
    modport sink   (input valid, input cmd, input number, input character,
                    input position, output ready);

endinterface

>>> rtl/ssd_rsp_if.sv
// Response channel of the seven-segment scan driver: segment and digit pin beats.
interface ssd_rsp_if import ssd_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [SEG_W-1:0]   segments;
    logic [DIGIT_W-1:0] digit_select;

    modport source (output valid, output segments, output digit_select, input ready);
    modport sink   (input valid, input segments, input digit_select, output ready);

endinterface

>>> rtl/seven_segment_scan_driver_top.sv
// A scan tick while scanning, or a stop beat, shows its pin beat on rsp in the cycle after acceptance.
// Throughput: one request beat per cycle; the single result register frees in the same
// cycle that rsp takes its beat, so the only stall is a held response.
// Number conversion uses three constant-reciprocal multiplies in parallel, all combinational.
// Reset (rst_n low, asynchronous): digits hold '0', scanning stopped, phase 0, pins dark,
// digit select 0, no response pending.
`include "seven_segment_scan_driver_top_macros.svh"

module seven_segment_scan_driver_top
    import ssd_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    ssd_req_if.sink   req,
    ssd_rsp_if.source rsp
);

    // Active-low a-g pattern for a character; known is low for characters
    // that have no glyph, in which case the pins keep their old pattern.
    function automatic seg_decode_t decode_char(input logic [CHAR_W-1:0] ch);
        seg_decode_t d;
        d.known = 1'b1;
        case (ch)
            8'h30:   d.pattern = 7'h40;  // 0
            8'h31:   d.pattern = 7'h79;  // 1
            8'h32:   d.pattern = 7'h24;  // 2
            8'h33:   d.pattern = 7'h30;  // 3
            8'h34:   d.pattern = 7'h19;  // 4
            8'h35:   d.pattern = 7'h12;  // 5
            8'h36:   d.pattern = 7'h02;  // 6
            8'h37:   d.pattern = 7'h78;  // 7
            8'h38:   d.pattern = 7'h00;  // 8
            8'h39:   d.pattern = 7'h10;  // 9
            8'h41:   d.pattern = 7'h08;  // A
            8'h42:   d.pattern = 7'h03;  // B
            8'h43:   d.pattern = 7'h46;  // C
            8'h44:   d.pattern = 7'h21;  // D
            8'h45:   d.pattern = 7'h06;  // E
            8'h46:   d.pattern = 7'h0E;  // F
            8'h47:   d.pattern = 7'h10;  // G
            8'h48:   d.pattern = 7'h09;  // H
            8'h49:   d.pattern = 7'h4F;  // I
            8'h4A:   d.pattern = 7'h61;  // J
            8'h4C:   d.pattern = 7'h47;  // L
            8'h4F:   d.pattern = 7'h23;  // O
            8'h50:   d.pattern = 7'h0C;  // P
            8'h51:   d.pattern = 7'h18;  // Q
            8'h55:   d.pattern = 7'h41;  // U
            8'h61:   d.pattern = 7'h7E;  // a: segment a alone
            8'h62:   d.pattern = 7'h7D;  // b: segment b alone
            8'h63:   d.pattern = 7'h7B;  // c: segment c alone
            8'h64:   d.pattern = 7'h77;  // d: segment d alone
            8'h65:   d.pattern = 7'h6F;  // e: segment e alone
            8'h66:   d.pattern = 7'h5F;  // f: segment f alone
            8'h67:   d.pattern = 7'h3F;  // g: segment g alone, the minus sign
            default:
            begin
                d.known   = 1'b0;
                d.pattern = 7'h7F;
            end
        endcase
        return d;
    endfunction

    // Splits a signed number into four ASCII digits with leading zeros, a minus in the top digit
    // for negatives, or F U U U when out of range. The quotients by 10, 100 and 1000 come from
    // scaled reciprocals, which are exact for every magnitude up to 9999; the digits then follow
    // from one multiply-by-ten and subtract each.
    function automatic digit_row_t number_to_chars(input logic signed [NUMBER_W-1:0] num);
        digit_row_t          row;
        logic [NUMBER_W-1:0] neg;
        logic [13:0]         mag;
        logic [27:0]         p10;
        logic [27:0]         p100;
        logic [27:0]         p1000;
        logic [9:0]          q10;
        logic [6:0]          q100;
        logic [3:0]          q1000;
        logic [13:0]         ones_full;
        logic [9:0]          tens_full;
        logic [6:0]          hund_full;
        neg       = -num;
        mag       = num[NUMBER_W-1] ? neg[13:0] : num[13:0];
        p10       = {14'd0, mag} * 28'd6554;
        p100      = {14'd0, mag} * 28'd5243;
        p1000     = {14'd0, mag} * 28'd16778;
        q10       = p10[25:16];
        q100      = p100[25:19];
        q1000     = p1000[27:24];
        ones_full = mag - ({4'd0, q10} * 14'd10);
        tens_full = q10 - ({3'd0, q100} * 10'd10);
        hund_full = q100 - ({3'd0, q1000} * 7'd10);
        if (num < NUM_MIN || num > NUM_MAX)
        begin
            row = {CHAR_F, CHAR_U, CHAR_U, CHAR_U};
        end
        else
        begin
            row[0] = CHAR_ZERO | {4'd0, ones_full[3:0]};
            row[1] = CHAR_ZERO | {4'd0, tens_full[3:0]};
            row[2] = CHAR_ZERO | {4'd0, hund_full[3:0]};
            row[3] = num[NUMBER_W-1] ? CHAR_MINUS : (CHAR_ZERO | {4'd0, q1000});
        end
        return row;
    endfunction

    // Display state.
    digit_row_t         digit_reg;
    digit_row_t         digit_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [SEG_W-1:0]   seg_reg;
    logic [SEG_W-1:0]   seg_next;
    logic [DIGIT_W-1:0] select_reg;
    logic [DIGIT_W-1:0] select_next;
    logic               scanning_reg;
    logic               scanning_next;

    // Result register toward rsp.
    logic               out_valid_reg;
    logic [SEG_W-1:0]   out_seg_reg;
    logic [DIGIT_W-1:0] out_select_reg;

    logic               accept;
    logic               result_fire;
    seg_decode_t        glyph;

    // A new beat is taken whenever the result register is empty or is being
    // drained in this very cycle.
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // The glyph of the digit under the scan; phase 4 never uses it.
    assign glyph = decode_char(digit_reg[phase_reg[DIGIT_W-1:0]]);

    // All effects of one beat are worked out here and land in the state
    // registers at the accepting edge. Only a scan tick while scanning and a
    // stop produce a response beat, which carries the pins after the update.
    always_comb
    begin
        digit_next    = digit_reg;
        phase_next    = phase_reg;
        seg_next      = seg_reg;
        select_next   = select_reg;
        scanning_next = scanning_reg;
        result_fire   = 1'b0;
        if (accept)
        begin
            case (req.cmd)
                CMD_SET_NUMBER:
                begin
                    digit_next = number_to_chars(req.number);
                end
                CMD_SET_CHAR:
                begin
                    digit_next[req.position] = req.character;
                end
                CMD_SCAN_TICK:
                begin
                    if (scanning_reg)
                    begin
                        result_fire = 1'b1;
                        if (phase_reg < PHASE_WRAP)
                        begin
                            select_next = phase_reg[DIGIT_W-1:0];
                            if (glyph.known)
                            begin
                                seg_next = {seg_reg[SEG_W-1], glyph.pattern};
                            end
                            phase_next = phase_reg + 1'b1;
                        end
                        else
                        begin
                            // The extra phase only closes the scan frame.
                            phase_next = '0;
                        end
                    end
                end
                CMD_STOP:
                begin
                    scanning_next = 1'b0;
                    seg_next      = SEG_DARK;
                    result_fire   = 1'b1;
                end
                CMD_START:
                begin
                    scanning_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg     <= {DIGITS{CHAR_ZERO}};
            phase_reg     <= '0;
            seg_reg       <= SEG_DARK;
            select_reg    <= '0;
            scanning_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            digit_reg    <= digit_next;
            phase_reg    <= phase_next;
            seg_reg      <= seg_next;
            select_reg   <= select_next;
            scanning_reg <= scanning_next;
            if (result_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_fire)
        begin
            out_seg_reg    <= seg_next;
            out_select_reg <= select_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.segments     = out_seg_reg;
    assign rsp.digit_select = out_select_reg;

    // The scan phase never leaves the five-step frame.
    `SSD_ASSERT_SAME(a_phase_in_frame, clk, rst_n, 1'b1, phase_reg <= PHASE_WRAP)
    // The decimal point pin is never lit by decoding.
    `SSD_ASSERT_SAME(a_point_dark, clk, rst_n, 1'b1, seg_reg[SEG_W-1])
    // A stop beat yields a pending beat showing all segments dark.
    `SSD_ASSERT_NEXT(a_stop_blanks, clk, rst_n, accept && req.cmd == CMD_STOP,
        out_valid_reg && out_seg_reg == SEG_DARK && !scanning_reg)
    // A start beat leaves the scan running.
    `SSD_ASSERT_NEXT(a_start_runs, clk, rst_n, accept && req.cmd == CMD_START, scanning_reg)
    // A response beat only appears as the result of an accepted request.
    `SSD_ASSERT_SAME(a_rsp_from_req, clk, rst_n, $rose(out_valid_reg), $past(accept))

endmodule

>>> bench/tb_top.sv
// Self-checking testbench for the seven-segment scan driver: directed and random command beats.
module tb_top;
    import ssd_pkg::*;

    // Command codes 5 to 7 are not assigned, and the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    localparam int RANDOM_ITEMS = 450;
    // In the final stretch of the random part neither side idles.
    localparam int CALM_ITEMS   = 60;
    // The block answers in the cycle after acceptance, so a short tail is plenty.
    localparam int TAIL_CYCLES  = 10;
    // Neither side idles without bound, so a long run of nothing accepted is a hang.
    localparam int STALL_LIMIT  = 1000;

    // Every character that the segment decoder knows; random writes draw mostly from here.
    localparam string KNOWN_GLYPHS = "0123456789ABCDEFGHIJLOPQUabcdefg";

    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [DIGIT_W-1:0] digit_select;
    } pin_beat_t;

    // The scoreboard carries its own copy of the display state. Every accepted
    // command beat moves that state and may queue the pin beat that it causes;
    // every pin beat from the block is checked against the oldest one queued.
    class display_scoreboard;
        logic [CHAR_W-1:0]  glyph_store [DIGITS];
        logic [PHASE_W-1:0] scan_step;
        logic [SEG_W-1:0]   seg_pins;
        logic [DIGIT_W-1:0] sel_pins;
        bit                 scanning;
        pin_beat_t          pending_pins [$];
        int                 errors;

        function new();
            foreach (glyph_store[k])
                glyph_store[k] = CHAR_ZERO;
            scan_step = '0;
            seg_pins  = SEG_DARK;
            sel_pins  = '0;
            scanning  = 1'b0;
            errors    = 0;
        endfunction

        // Active-low a-g pattern; returns 0 when the character has no glyph.
        function bit glyph_pattern(input logic [CHAR_W-1:0] ch, output logic [6:0] pat);
            pat = 7'h7F;
            case (ch)
                "0": pat = 7'h40;
                "1": pat = 7'h79;
                "2": pat = 7'h24;
                "3": pat = 7'h30;
                "4": pat = 7'h19;
                "5": pat = 7'h12;
                "6": pat = 7'h02;
                "7": pat = 7'h78;
                "8": pat = 7'h00;
                "9": pat = 7'h10;
                "A": pat = 7'h08;
                "B": pat = 7'h03;
                "C": pat = 7'h46;
                "D": pat = 7'h21;
                "E": pat = 7'h06;
                "F": pat = 7'h0E;
                "G": pat = 7'h10;
                "H": pat = 7'h09;
                "I": pat = 7'h4F;
                "J": pat = 7'h61;
                "L": pat = 7'h47;
                "O": pat = 7'h23;
                "P": pat = 7'h0C;
                "Q": pat = 7'h18;
                "U": pat = 7'h41;
                "a": pat = 7'h7E;
                "b": pat = 7'h7D;
                "c": pat = 7'h7B;
                "d": pat = 7'h77;
                "e": pat = 7'h6F;
                "f": pat = 7'h5F;
                "g": pat = 7'h3F;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void load_decimal(input logic signed [NUMBER_W-1:0] value);
            int v;
            int mag;
            v = value;
            if (v < NUM_MIN || v > NUM_MAX) begin
                glyph_store[3] = CHAR_F;
                glyph_store[2] = CHAR_U;
                glyph_store[1] = CHAR_U;
                glyph_store[0] = CHAR_U;
                return;
            end
            mag = (v < 0) ? -v : v;
            for (int k = 0; k < DIGITS; k++)
            begin
                glyph_store[k] = CHAR_ZERO + CHAR_W'(mag % 10);
                mag = mag / 10;
            end
            if (v < 0)
                glyph_store[3] = CHAR_MINUS;
        endfunction

        // Returns 1 when the beat does something, 0 when the block ignores it.
        function bit note_request(input logic [CMD_W-1:0] op,
                                  input logic signed [NUMBER_W-1:0] value,
                                  input logic [CHAR_W-1:0] glyph,
                                  input logic [DIGIT_W-1:0] slot);
            logic [6:0] pat;
            case (op)
                CMD_SET_NUMBER: load_decimal(value);
                CMD_SET_CHAR:   glyph_store[slot] = glyph;
                CMD_SCAN_TICK:
                begin
                    if (!scanning)
                        return 1'b0;
                    if (scan_step < PHASE_WRAP)
                    begin
                        sel_pins = scan_step[DIGIT_W-1:0];
                        if (glyph_pattern(glyph_store[scan_step[DIGIT_W-1:0]], pat))
                            seg_pins = {seg_pins[SEG_W-1], pat};
                        scan_step = scan_step + 1'b1;
                    end
                    else
                        scan_step = '0;
                    pending_pins.push_back('{segments: seg_pins, digit_select: sel_pins});
                end
                CMD_STOP:
                begin
                    scanning = 1'b0;
                    seg_pins = SEG_DARK;
                    pending_pins.push_back('{segments: seg_pins, digit_select: sel_pins});
                end
                CMD_START: scanning = 1'b1;
                default: return 1'b0;
            endcase
            return 1'b1;
        endfunction

        function void check_pins(input logic [SEG_W-1:0] segments,
                                 input logic [DIGIT_W-1:0] digit_select);
            pin_beat_t want;
            if (pending_pins.size() == 0)
            begin
                $display("%0t: unexpected pin beat segments=%h digit_select=%0d",
                         $time, segments, digit_select);
                errors++;
                return;
            end
            want = pending_pins.pop_front();
            if (segments !== want.segments)
            begin
                $display("%0t: segments expected %h actual %h", $time, want.segments, segments);
                errors++;
            end
            if (digit_select !== want.digit_select)
            begin
                $display("%0t: digit_select expected %0d actual %0d",
                         $time, want.digit_select, digit_select);
                errors++;
            end
        endfunction

        function int pending();
            return pending_pins.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ssd_req_if req_ch ();
    ssd_rsp_if rsp_ch ();

    seven_segment_scan_driver_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    display_scoreboard sb = new();

    // Number of accepted beats that did something, and cycles since the last beat of any kind.
    int applied_items = 0;
    int stalled       = 0;
    // Set for the final stretch of the run, where both sides run flat out.
    bit calm          = 1'b0;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Inputs have known values from time zero; reset is asserted once, at the start.
    initial
    begin
        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.cmd       = CMD_START;
        req_ch.number    = '0;
        req_ch.character = '0;
        req_ch.position  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // The response side holds ready high for random stretches and at random drops it
    // between them, so that stalls land on every phase of the scan.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
        end
    end

    // Both channels are sampled here at the rising edge. A pin beat that leaves
    // in the same cycle as a command beat arrives always belongs to an older
    // command, so it is checked before the new command updates the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_pins(rsp_ch.segments, rsp_ch.digit_select);
            if (req_ch.valid && req_ch.ready)
            begin
                if (sb.note_request(req_ch.cmd, req_ch.number, req_ch.character,
                                    req_ch.position))
                    applied_items <= applied_items + 1;
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stalled <= 0;
            else
                stalled <= stalled + 1;
        end
    end

    // A run that stops accepting anything on either side for too long has hung.
    initial
    begin
        while (stalled < STALL_LIMIT)
            @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // Offers one command beat, starting at a falling edge, and returns at the
    // falling edge after it is taken. A random gap may come first. Valid stays
    // high between back-to-back beats, so it is never dropped and raised in one step.
    task automatic send_beat(input logic [CMD_W-1:0] op,
                             input logic signed [NUMBER_W-1:0] value,
                             input logic [CHAR_W-1:0] glyph,
                             input logic [DIGIT_W-1:0] slot);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        req_ch.valid     = 1'b1;
        req_ch.cmd       = op;
        req_ch.number    = value;
        req_ch.character = glyph;
        req_ch.position  = slot;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // The payload fields that a command does not use carry random noise.
    task automatic send_op(input logic [CMD_W-1:0] op);
        send_beat(op, NUMBER_W'($urandom), CHAR_W'($urandom), DIGIT_W'($urandom));
    endtask

    task automatic send_number(input logic signed [NUMBER_W-1:0] value);
        send_beat(CMD_SET_NUMBER, value, CHAR_W'($urandom), DIGIT_W'($urandom));
    endtask

    task automatic send_glyph(input logic [CHAR_W-1:0] glyph, input logic [DIGIT_W-1:0] slot);
        send_beat(CMD_SET_CHAR, NUMBER_W'($urandom), glyph, slot);
    endtask

    initial
    begin
        int target;
        int pick;
        logic [CHAR_W-1:0] glyph;
        logic signed [NUMBER_W-1:0] value;

        @(posedge rst_n);
        @(negedge clk);

        // Directed part. A tick before the first start must be ignored.
        send_op(CMD_SCAN_TICK);
        send_op(CMD_START);
        // The largest number that fits, scanned through all four digits and the wrap phase.
        send_number(NUM_MAX);
        repeat (5) send_op(CMD_SCAN_TICK);
        // Just below the negative limit the display shows F U U U.
        send_number(NUM_MIN - 1'b1);
        repeat (4) send_op(CMD_SCAN_TICK);
        // Characters with no glyph leave the segment pins as they were.
        send_glyph(8'h00, 2'd0);
        send_glyph(8'hFF, 2'd3);
        repeat (2) send_op(CMD_SCAN_TICK);
        // Most negative number that fits, with the minus sign in the top digit.
        send_number(NUM_MIN);
        send_op(CMD_STOP);
        // Ticks while stopped do nothing; unassigned codes are ignored as well.
        send_op(CMD_SCAN_TICK);
        send_op(CMD_START);
        send_op(CMD_UNUSED_FIRST);
        send_op(CMD_UNUSED_LAST);
        send_number(16'sh8000);
        send_number(16'sh7FFF);
        send_number(16'sh0000);
        send_op(CMD_SCAN_TICK);

        // Random part. Most traffic keeps the block scanning so that stored digits
        // reach the pins; stops, restarts, ignored ticks and unused codes are mixed in.
        target = applied_items + RANDOM_ITEMS;
        while (applied_items < target)
        begin
            calm = (applied_items >= target - CALM_ITEMS);
            pick = $urandom_range(0, 99);
            if (!sb.scanning && pick < 70)
                send_op(CMD_START);
            else if (pick < 50)
                send_op(CMD_SCAN_TICK);
            else if (pick < 65)
            begin
                case ($urandom_range(0, 3))
                    0: value = NUMBER_W'($urandom);
                    1: value = NUM_MAX + $signed(NUMBER_W'($urandom_range(0, 2))) - 16'sd1;
                    2: value = NUM_MIN + $signed(NUMBER_W'($urandom_range(0, 2))) - 16'sd1;
                    default: value = $signed(NUMBER_W'($urandom_range(0, 10998))) - 16'sd999;
                endcase
                send_number(value);
            end
            else if (pick < 82)
            begin
                if ($urandom_range(0, 9) < 7)
                    glyph = KNOWN_GLYPHS[$urandom_range(0, KNOWN_GLYPHS.len() - 1)];
                else
                    glyph = CHAR_W'($urandom);
                send_glyph(glyph, DIGIT_W'($urandom));
            end
            else if (pick < 88)
                send_op(CMD_STOP);
            else if (pick < 94)
                send_op(CMD_START);
            else
                send_op(CMD_W'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)));
        end
        req_ch.valid = 1'b0;

        // Drain: every queued pin beat must arrive, then a few quiet cycles follow
        // so that any stray beat from the block still gets caught.
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
